// ===== sv/rf1d_pkg.sv =====
`default_nettype none
package rf1d_pkg;

  localparam int FRAC_BITS      = 16;
  localparam int LOG_TABLE_BITS = 8;
  localparam int TABLE_SIZE     = 1 << LOG_TABLE_BITS;
  localparam int DATA_W         = 32;
  localparam int CFG_W          = 31;

  localparam logic [63:0] LN2_Q30 = 64'd744261118;
  // ln2 in the working fixed format, rounded
  localparam logic [63:0] LN2_FIX_W =
    (LN2_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
  localparam logic signed [DATA_W-1:0] LN2_FIX = $signed(LN2_FIX_W[DATA_W-1:0]);

  // cell phase codes
  localparam logic [1:0] PH_FIRST = 2'd0;
  localparam logic [1:0] PH_ONE   = 2'd1;
  localparam logic [1:0] PH_TWO   = 2'd2;

  // register indexes
  localparam logic [1:0] REG_STEP_RATIO     = 2'd0;
  localparam logic [1:0] REG_TIME_STEP      = 2'd1;
  localparam logic [1:0] REG_PRESSURE_GAIN  = 2'd2;
  localparam logic [1:0] REG_COLLISION_RATE = 2'd3;

  typedef logic signed [DATA_W-1:0] log_table_t [TABLE_SIZE];

  // per-item tags that ride along the pipeline
  typedef struct packed {
    logic signed [DATA_W-1:0] n;
    logic signed [DATA_W-1:0] v;
    logic signed [DATA_W-1:0] hn;
    logic signed [DATA_W-1:0] hv;
    logic signed [DATA_W-1:0] hs;
    logic                     last;
    logic [1:0]               phase;
  } meta_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] n;
    logic signed [DATA_W-1:0] v;
    logic                     bnd;
    logic                     last;
  } res_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (x < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return x[DATA_W-1:0];
    end
  endfunction

  // ln(1 + k/2^LOG_TABLE_BITS): log2 by repeated squaring, then times ln2
  function automatic log_table_t build_log_table();
    log_table_t  t;
    logic [63:0] m;
    logic [63:0] y;
    logic [63:0] r;
    for (int k = 0; k < TABLE_SIZE; k++) begin
      m = (64'd1 << 30) + (64'(k) << (30 - LOG_TABLE_BITS));
      y = 64'd0;
      for (int i = 1; i <= 30; i++) begin
        m = (m * m) >> 30;
        if (m >= (64'd1 << 31)) begin
          m = m >> 1;
          y = y | (64'd1 << (30 - i));
        end
      end
      r = (y * LN2_Q30 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
      t[k] = $signed(r[DATA_W-1:0]);
    end
    return t;
  endfunction

  localparam log_table_t LOG_TABLE = build_log_table();

endpackage
`default_nettype wire

// ===== sv/rf1d_flux.sv =====
`default_nettype none
// Density and velocity flux of one cell, three register stages.
module rf1d_flux (
  input  wire logic                                 clk,
  input  wire logic                                 en,
  input  wire logic signed [rf1d_pkg::DATA_W-1:0]   n,
  input  wire logic signed [rf1d_pkg::DATA_W-1:0]   v,
  input  wire logic [rf1d_pkg::CFG_W-1:0]           pressure_gain,
  output logic signed [rf1d_pkg::DATA_W-1:0]        dflux,
  output logic signed [rf1d_pkg::DATA_W-1:0]        vflux
);
  import rf1d_pkg::*;

  logic [DATA_W-2:0]         u;
  logic [4:0]                lead;
  logic [DATA_W+LOG_TABLE_BITS-2:0] ush;
  logic [LOG_TABLE_BITS-1:0] idx;
  logic signed [DATA_W-1:0]  ln_c;
  logic signed [63:0]        nv;
  logic signed [63:0]        vv;
  logic signed [63:0]        pl;

  logic signed [DATA_W-1:0]  s1_df, s1_kin, s1_ln;
  logic signed [DATA_W-1:0]  s2_df, s2_kin, s2_prs;

  always_comb begin
    // non-positive density clamps to one LSB
    u = (n <= 0) ? (DATA_W-1)'(1) : n[DATA_W-2:0];
    lead = '0;
    for (int p = 0; p < DATA_W-1; p++) begin
      if (u[p]) lead = 5'(p);
    end
    ush  = {u, {LOG_TABLE_BITS{1'b0}}} >> lead;
    idx  = ush[LOG_TABLE_BITS-1:0];
    ln_c = DATA_W'((32'(lead) - FRAC_BITS) * LN2_FIX) + LOG_TABLE[idx];
    nv   = 64'(n) * 64'(v);
    vv   = 64'(v) * 64'(v);
    pl   = 64'($signed({1'b0, pressure_gain})) * 64'(s1_ln);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_df  <= sat32(nv >>> FRAC_BITS);
      s1_kin <= sat32(vv >>> (FRAC_BITS + 1));
      s1_ln  <= ln_c;
      s2_df  <= s1_df;
      s2_kin <= s1_kin;
      s2_prs <= sat32(pl >>> FRAC_BITS);
      dflux  <= s2_df;
      vflux  <= sat32(64'(s2_kin) + 64'(s2_prs));
    end
  end

endmodule
`default_nettype wire

// ===== sv/rf1d_out.sv =====
`default_nettype none
// Result slot: holds one finished item, gives out its update then its boundary beat.
module rf1d_out (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire logic              load_upd,
  input  wire logic              load_bnd,
  input  wire rf1d_pkg::res_t    upd_res,
  input  wire rf1d_pkg::res_t    bnd_res,
  output logic                   free,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output rf1d_pkg::res_t         out_res
);
  import rf1d_pkg::*;

  logic upd_pend, bnd_pend;
  res_t upd_q, bnd_q;
  logic out_acc;

  assign out_valid = upd_pend | bnd_pend;
  assign out_acc   = out_valid & ~out_stall;
  assign free      = ~out_valid | (out_acc & ~(upd_pend & bnd_pend));
  assign out_res   = upd_pend ? upd_q : bnd_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      upd_pend <= 1'b0;
      bnd_pend <= 1'b0;
    end else if (load) begin
      upd_pend <= load_upd;
      bnd_pend <= load_bnd;
    end else if (out_acc) begin
      if (upd_pend) begin
        upd_pend <= 1'b0;
      end else begin
        bnd_pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      upd_q <= upd_res;
      bnd_q <= bnd_res;
    end
  end

endmodule
`default_nettype wire

// ===== sv/richtmyer_fluid_1d_step_core.sv =====
`default_nettype none
// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------------
// in       | in_valid / in_stall  | density_in, velocity_in, last_cell
// out      | out_valid / out_stall| density_out, velocity_out, boundary_cell,
//          |                      | last_out
// cfg      | APB psel/penable     | paddr, pwdata, prdata
//
// One beat enters per cycle unless stalled; it flows through m[0] to m[13].
// A final cell that follows an interior cell yields two result beats, which holds
// the pipe until the update beat goes out.
// The whole pipe advances on one enable set by the result slot, so a stall
// holds every stage in place. Reset clears vld and cell_phase, presets config.
module richtmyer_fluid_1d_step_core
  import rf1d_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic signed [DATA_W-1:0]   density_in,
  input  wire logic signed [DATA_W-1:0]   velocity_in,
  input  wire logic                       last_cell,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [DATA_W-1:0]        density_out,
  output logic signed [DATA_W-1:0]        velocity_out,
  output logic                            boundary_cell,
  output logic                            last_out,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [3:0]                 paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int LAST_ST = 13;

  // config registers
  logic [CFG_W-1:0] step_ratio, time_step, pressure_gain, collision_rate;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_ratio     <= CFG_W'(6554);
      time_step      <= CFG_W'(66);
      pressure_gain  <= CFG_W'(32768);
      collision_rate <= CFG_W'(0);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_STEP_RATIO:     step_ratio     <= pwdata[CFG_W-1:0];
        REG_TIME_STEP:      time_step      <= pwdata[CFG_W-1:0];
        REG_PRESSURE_GAIN:  pressure_gain  <= pwdata[CFG_W-1:0];
        REG_COLLISION_RATE: collision_rate <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_STEP_RATIO:     prdata = {1'b0, step_ratio};
      REG_TIME_STEP:      prdata = {1'b0, time_step};
      REG_PRESSURE_GAIN:  prdata = {1'b0, pressure_gain};
      REG_COLLISION_RATE: prdata = {1'b0, collision_rate};
      default:            prdata = '0;
    endcase
  end

  logic signed [63:0] sr_s, ts_s, cr_s;
  assign sr_s = 64'($signed({1'b0, step_ratio}));
  assign ts_s = 64'($signed({1'b0, time_step}));
  assign cr_s = 64'($signed({1'b0, collision_rate}));

  // entry: phase tracking and the held (previous) cell
  logic                     adv, in_acc;
  logic [1:0]               cell_phase;
  logic signed [DATA_W-1:0] held_density, held_velocity;
  logic [1:0]               entry_phase;

  assign in_stall    = ~adv;
  assign in_acc      = in_valid & adv;
  assign entry_phase = (cell_phase == PH_ONE || cell_phase == PH_TWO) ? cell_phase : PH_FIRST;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_phase <= PH_FIRST;
    end else if (in_acc) begin
      if (last_cell) begin
        cell_phase <= PH_FIRST;
      end else if (entry_phase == PH_FIRST) begin
        cell_phase <= PH_ONE;
      end else begin
        cell_phase <= PH_TWO;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      held_density  <= density_in;
      held_velocity <= velocity_in;
    end
  end

  // tag line and valid bits
  meta_t            m [LAST_ST+1];
  logic [LAST_ST:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAST_ST-1:0], in_acc};
    end
  end

  // held cell's damping term, two multiply stages
  logic signed [63:0] hs_p1, hs_p2;
  meta_t              m1_next, m2_next;
  assign hs_p1 = cr_s * 64'(m[0].hv);
  assign hs_p2 = ts_s * 64'(m[1].hs);

  always_comb begin
    m1_next    = m[0];
    m1_next.hs = sat32(-(hs_p1 >>> FRAC_BITS));
    m2_next    = m[1];
    m2_next.hs = sat32(hs_p2 >>> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m[0] <= '{n: density_in, v: velocity_in, hn: held_density, hv: held_velocity,
                hs: '0, last: last_cell, phase: entry_phase};
      m[1] <= m1_next;
      m[2] <= m2_next;
      for (int i = 3; i <= LAST_ST; i++) begin
        m[i] <= m[i-1];
      end
    end
  end

  // first-step flux of the incoming cell
  logic signed [DATA_W-1:0] fa_df, fa_vf, pa_df, pa_vf;

  rf1d_flux u_flux_a (
    .clk           (clk),
    .en            (adv),
    .n             (m[0].n),
    .v             (m[0].v),
    .pressure_gain (pressure_gain),
    .dflux         (fa_df),
    .vflux         (fa_vf)
  );

  // midpoint between held cell and incoming cell
  logic signed [DATA_W-1:0] r4_dn, r4_dv, r4_an, r4_av;
  logic signed [DATA_W-1:0] r5_tn, r5_tv, r5_src, r5_an, r5_av;
  logic signed [DATA_W-1:0] r6_sv, r6_mn;
  logic signed [63:0]       r6_mvp;
  logic signed [DATA_W-1:0] r7_mn, r7_mv;
  logic signed [63:0]       avg_n_w, avg_v_w, p5_tn, p5_tv, p5_src, p6_sv;

  assign avg_n_w = (64'(m[3].n) + 64'(m[3].hn)) >>> 1;
  assign avg_v_w = (64'(m[3].v) + 64'(m[3].hv)) >>> 1;
  assign p5_tn   = sr_s * 64'(r4_dn);
  assign p5_tv   = sr_s * 64'(r4_dv);
  assign p5_src  = cr_s * 64'(r4_av);
  assign p6_sv   = ts_s * 64'(r5_src);

  always_ff @(posedge clk) begin
    if (adv) begin
      if (vld[3]) begin
        pa_df <= fa_df;
        pa_vf <= fa_vf;
      end
      r4_dn  <= sat32(64'(fa_df) - 64'(pa_df));
      r4_dv  <= sat32(64'(fa_vf) - 64'(pa_vf));
      r4_an  <= avg_n_w[DATA_W-1:0];
      r4_av  <= avg_v_w[DATA_W-1:0];
      r5_tn  <= sat32(p5_tn >>> (FRAC_BITS + 1));
      r5_tv  <= sat32(p5_tv >>> (FRAC_BITS + 1));
      r5_src <= sat32(-(p5_src >>> FRAC_BITS));
      r5_an  <= r4_an;
      r5_av  <= r4_av;
      r6_sv  <= sat32(p6_sv >>> (FRAC_BITS + 1));
      r6_mn  <= sat32(64'(r5_an) - 64'(r5_tn));
      r6_mvp <= 64'(r5_av) - 64'(r5_tv);
      r7_mn  <= r6_mn;
      r7_mv  <= sat32(r6_mvp + 64'(r6_sv));
    end
  end

  // second-step flux of the midpoint
  logic signed [DATA_W-1:0] fb_df, fb_vf, pb_df, pb_vf;

  rf1d_flux u_flux_b (
    .clk           (clk),
    .en            (adv),
    .n             (r7_mn),
    .v             (r7_mv),
    .pressure_gain (pressure_gain),
    .dflux         (fb_df),
    .vflux         (fb_vf)
  );

  logic signed [DATA_W-1:0] r11_dn, r11_dv, r12_tn, r12_tv, r13_n, r13_v;
  logic signed [63:0]       p12_tn, p12_tv;

  assign p12_tn = sr_s * 64'(r11_dn);
  assign p12_tv = sr_s * 64'(r11_dv);

  always_ff @(posedge clk) begin
    if (adv) begin
      if (vld[10]) begin
        pb_df <= fb_df;
        pb_vf <= fb_vf;
      end
      r11_dn <= sat32(64'(fb_df) - 64'(pb_df));
      r11_dv <= sat32(64'(fb_vf) - 64'(pb_vf));
      r12_tn <= sat32(p12_tn >>> FRAC_BITS);
      r12_tv <= sat32(p12_tv >>> FRAC_BITS);
      r13_n  <= sat32(64'(m[12].hn) - 64'(r12_tn));
      r13_v  <= sat32(64'(m[12].hv) - 64'(r12_tv) + 64'(m[12].hs));
    end
  end

  // result slot
  res_t upd_res, bnd_res, out_res;
  logic load;

  assign load    = adv & vld[LAST_ST];
  assign upd_res = '{n: r13_n, v: r13_v, bnd: 1'b0, last: 1'b0};
  assign bnd_res = '{n: m[LAST_ST].n, v: m[LAST_ST].v, bnd: 1'b1, last: m[LAST_ST].last};

  rf1d_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .load_upd  (m[LAST_ST].phase == PH_TWO),
    .load_bnd  (m[LAST_ST].phase == PH_FIRST || m[LAST_ST].last),
    .upd_res   (upd_res),
    .bnd_res   (bnd_res),
    .free      (adv),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign density_out   = out_res.n;
  assign velocity_out  = out_res.v;
  assign boundary_cell = out_res.bnd;
  assign last_out      = out_res.last;

`ifndef SYNTHESIS
  a_hold_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld)) else $error("pipe moved while blocked");
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> vld[0]) else $error("accepted beat missing at entry");
  a_first_emits: assert property (@(posedge clk) disable iff (rst)
    load && m[LAST_ST].phase == PH_FIRST |=> out_valid && boundary_cell)
    else $error("first cell not emitted");
`endif

endmodule
`default_nettype wire
